/* rtl/core/jpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpe_pkg
// Shared types, constants and helpers for the Jacobi polynomial evaluator.
// ----------------------------------------------------------------------------
package jpe_pkg;

    localparam int MAX_DEGREE = 31;
    localparam int DEG_W      = 5;
    localparam int X_W        = 32;
    localparam int W_W        = 21;
    localparam int IN_TDATA_W = 40;

    localparam logic signed [63:0] Q16_ONE = 64'sd65536;
    localparam logic signed [63:0] Q32_ONE = 64'sh0000_0001_0000_0000;

    // rounding shift codes for the shared multiplier
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_15 = 2'd1;
    localparam logic [1:0] SH_16 = 2'd2;
    localparam logic [1:0] SH_30 = 2'd3;

    // configuration register indexes
    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_BETA  = 1'b1;

    typedef struct packed {
        logic [63:0] val;
        logic        ovf;
    } t_sat;

    function automatic t_sat f_sat(input logic [127:0] v);
        t_sat r;
        if (v[127:63] == {65{v[127]}}) begin
            r.val = v[63:0];
            r.ovf = 1'b0;
        end else begin
            r.val = v[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [63:0] f_mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

/* rtl/core/jacobi_polynomial_eval_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_polynomial_eval_unit
// Jacobi polynomial P_k^(alpha,beta)(x) by three-term recurrence, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_axis carry the degree k and the point x (Q2.30). Each
//   accepted beat yields one beat on m_axis: P_k(x) in Q32.32 on tdata and
//   the saturation flag on tuser.
//   Alpha and beta (Q5.16) are written on the cfg channel, index 0 and 1;
//   cfg ready is always high. Write only while the unit is idle.
//   One item at a time: s_axis_tready is high only when idle.
//   One 32x32 multiplier, run four times per 64x64 product, and a 1-bit-per-
//   cycle 128/64 divider do all the work. Each recurrence step takes 11
//   products and one division. k=0 needs no arithmetic, k=1 one product,
//   higher k the P_1 product plus k-1 recurrence steps.
//   The result sits in an output register; a new item is taken while it
//   waits. If the receiver stalls, the next result holds in the sequencer
//   until the register is free. Reset (synchronous, active low) clears
//   alpha, beta, the state, op and count registers and the output valid.
// ----------------------------------------------------------------------------
module jacobi_polynomial_eval_unit
    import jpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [4:0] degree, [36:5] x_point
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata,   // [63:0] poly_value
    output logic                  m_axis_tuser,   // [0] saturated
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [W_W-1:0]        i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SEQ  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_RND  = 4'd3;
    localparam logic [3:0] S_NEG  = 4'd4;
    localparam logic [3:0] S_WB   = 4'd5;
    localparam logic [3:0] S_DSET = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DRND = 4'd8;
    localparam logic [3:0] S_DFIN = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    localparam logic [3:0] OP_P1  = 4'd0;
    localparam logic [3:0] OP_M0  = 4'd1;
    localparam logic [3:0] OP_C0  = 4'd2;
    localparam logic [3:0] OP_C1A = 4'd3;
    localparam logic [3:0] OP_C1  = 4'd4;
    localparam logic [3:0] OP_C2A = 4'd5;
    localparam logic [3:0] OP_C2  = 4'd6;
    localparam logic [3:0] OP_C3A = 4'd7;
    localparam logic [3:0] OP_C3  = 4'd8;
    localparam logic [3:0] OP_CX  = 4'd9;
    localparam logic [3:0] OP_PA  = 4'd10;
    localparam logic [3:0] OP_PB  = 4'd11;

    logic [3:0]               r_state;
    logic [3:0]               r_op;
    logic [6:0]               r_cnt;
    logic signed [W_W-1:0]    r_alpha, r_beta;
    logic [DEG_W-1:0]         r_k, r_j;
    logic signed [X_W-1:0]    r_x;
    logic [63:0]              r_p1, r_p2, r_c0, r_c1, r_c2, r_c3, r_t, r_tmp;
    logic [127:0]             r_num, r_acc, r_dq;
    logic [63:0]              r_ma, r_mb, r_dm, r_rem;
    logic                     r_mneg, r_dneg, r_flag;
    logic [1:0]               r_sh;
    logic                     r_ovalid, r_osat;
    logic [63:0]              r_oval;

    logic signed [63:0] w_s, w_d, w_n16, w_u, w_u1, w_u2, w_x64;
    logic signed [63:0] w_opa, w_opb;
    logic [1:0]         w_sh;
    logic [31:0]        w_pa, w_pb;
    logic [63:0]        w_pp;
    logic [127:0]       w_ppx, w_rnd;
    logic [64:0]        w_rs;
    logic               w_inc;
    t_sat               w_sat;

    assign w_s   = 64'(r_alpha) + 64'(r_beta);
    assign w_d   = 64'(r_alpha) - 64'(r_beta);
    assign w_n16 = 64'(r_j) <<< 16;
    assign w_u   = (w_n16 <<< 1) + w_s;
    assign w_u1  = w_u - Q16_ONE;
    assign w_u2  = w_u - (Q16_ONE <<< 1);
    assign w_x64 = 64'(r_x);

    always_comb begin
        w_opa = w_s;
        w_opb = w_u2;
        w_sh  = SH_16;
        unique case (r_op)
            OP_P1: begin
                w_opa = (Q16_ONE <<< 1) + w_s;
                w_opb = w_x64;
                w_sh  = SH_15;
            end
            OP_M0: begin
                w_opa = w_n16 + w_s;
                w_opb = w_u2;
            end
            OP_C0: begin
                w_opa = 64'(r_j) <<< 1;
                w_opb = r_tmp;
                w_sh  = SH_0;
            end
            OP_C1A: begin
                w_opa = w_u1;
                w_opb = w_d;
            end
            OP_C1: begin
                w_opa = r_tmp;
                w_opb = w_s;
            end
            OP_C2A: begin
                w_opa = w_u2;
                w_opb = w_u1;
            end
            OP_C2: begin
                w_opa = r_tmp;
                w_opb = w_u;
            end
            OP_C3A: begin
                w_opa = w_n16 + 64'(r_alpha) - Q16_ONE;
                w_opb = w_n16 + 64'(r_beta) - Q16_ONE;
            end
            OP_C3: begin
                w_opa = r_tmp;
                w_opb = w_u;
            end
            OP_CX: begin
                w_opa = r_c2;
                w_opb = w_x64;
                w_sh  = SH_30;
            end
            OP_PA: begin
                w_opa = r_t;
                w_opb = r_p1;
                w_sh  = SH_0;
            end
            OP_PB: begin
                w_opa = r_c3;
                w_opb = r_p2;
                w_sh  = SH_0;
            end
            default: begin
                w_opa = w_s;
                w_opb = w_u2;
                w_sh  = SH_16;
            end
        endcase
    end

    // partial products, low halves first
    assign w_pa = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_pb = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp = 64'(w_pa) * 64'(w_pb);

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_ppx = {64'd0, w_pp};
            2'd3:    w_ppx = {w_pp, 64'd0};
            default: w_ppx = {32'd0, w_pp, 32'd0};
        endcase
    end

    always_comb begin
        case (r_sh)
            SH_15:   w_rnd = (r_acc + (128'd1 << 14)) >> 15;
            SH_16:   w_rnd = (r_acc + (128'd1 << 15)) >> 16;
            SH_30:   w_rnd = (r_acc + (128'd1 << 29)) >> 30;
            default: w_rnd = r_acc;
        endcase
    end

    assign w_sat = f_sat(r_state == S_DFIN ? r_dq : r_acc);
    assign w_rs  = {r_rem, r_dq[127]};
    assign w_inc = (r_rem >= (r_dm - r_rem));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_alpha  <= '0;
            r_beta   <= '0;
            r_ovalid <= 1'b0;
            r_op     <= OP_P1;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_ALPHA) r_alpha <= i_cfg_data;
                if (i_cfg_index == REG_BETA)  r_beta  <= i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_k    <= s_axis_tdata[DEG_W-1:0];
                        r_x    <= s_axis_tdata[DEG_W+X_W-1:DEG_W];
                        r_j    <= DEG_W'(2);
                        r_flag <= 1'b0;
                        r_op   <= OP_P1;
                        if (s_axis_tdata[DEG_W-1:0] == '0) begin
                            r_p1    <= Q32_ONE;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SEQ;
                        end
                    end
                end
                S_SEQ: begin
                    r_ma    <= f_mag(w_opa);
                    r_mb    <= f_mag(w_opb);
                    r_mneg  <= w_opa[63] ^ w_opb[63];
                    r_sh    <= w_sh;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= r_acc + w_ppx;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt[1:0] == 2'd3) r_state <= S_RND;
                end
                S_RND: begin
                    r_acc   <= w_rnd;
                    r_state <= S_NEG;
                end
                S_NEG: begin
                    r_acc   <= r_mneg ? (128'd0 - r_acc) : r_acc;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_op <= r_op + 4'd1;
                    if (r_op != OP_PA && r_op != OP_PB) r_flag <= r_flag | w_sat.ovf;
                    if (r_op == OP_PB) begin
                        r_state <= S_DSET;
                    end else if (r_op == OP_P1 && r_k == DEG_W'(1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SEQ;
                    end
                    case (r_op) inside
                        OP_P1: begin
                            r_p2 <= Q32_ONE;
                            r_p1 <= w_sat.val + 64'(w_d <<< 15);
                        end
                        OP_M0, OP_C1A, OP_C2A, OP_C3A: r_tmp <= w_sat.val;
                        OP_C0: r_c0 <= w_sat.val;
                        OP_C1: r_c1 <= w_sat.val;
                        OP_C2: r_c2 <= w_sat.val;
                        OP_C3: r_c3 <= w_sat.val << 1;
                        OP_CX: r_t  <= r_c1 + w_sat.val;
                        OP_PA: r_num <= r_acc;
                        OP_PB: r_num <= r_num - r_acc;
                        default: r_tmp <= w_sat.val;
                    endcase
                end
                S_DSET: begin
                    r_dneg <= r_num[127] ^ r_c0[63];
                    r_dm   <= f_mag(r_c0);
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    if (r_c0 == '0) begin
                        // zero divisor: clamp to the numerator's sign
                        r_flag <= 1'b1;
                        r_dq   <= (r_num == '0) ? 128'd0 :
                                  r_num[127] ? {{65{1'b1}}, 63'd0} : {65'd0, {63{1'b1}}};
                        r_state <= S_DFIN;
                    end else begin
                        r_dq    <= r_num[127] ? (128'd0 - r_num) : r_num;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_rs >= {1'b0, r_dm}) begin
                        r_rem <= 64'(w_rs - {1'b0, r_dm});
                        r_dq  <= {r_dq[126:0], 1'b1};
                    end else begin
                        r_rem <= w_rs[63:0];
                        r_dq  <= {r_dq[126:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) r_state <= S_DRND;
                end
                S_DRND: begin
                    // -(q+inc) = ~q + !inc
                    r_dq    <= r_dneg ? (~r_dq + 128'(!w_inc)) : (r_dq + 128'(w_inc));
                    r_state <= S_DFIN;
                end
                S_DFIN: begin
                    r_p2   <= r_p1;
                    r_p1   <= w_sat.val;
                    r_flag <= r_flag | w_sat.ovf;
                    r_op   <= OP_M0;
                    if (r_j == r_k) begin
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_j + DEG_W'(1);
                        r_state <= S_SEQ;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_p1;
                        r_osat   <= r_flag;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_osat;
    assign o_cfg_ready   = 1'b1;

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dm))
        else $error("divider remainder not below divisor");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEQ && r_op != OP_P1) |-> (r_j >= DEG_W'(2) && r_j <= r_k))
        else $error("recurrence index out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_SEQ || r_state == S_OUT))
        else $error("accepted beat did not start work");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");
`endif

endmodule
